[rtl/pct_pkg.sv]
// ----------------------------------------------------------------------------
// pct_pkg
// Shared types and constants of the priority callback table.
// ----------------------------------------------------------------------------
package pct_pkg;

  localparam int unsigned HandleW = 32;
  localparam int unsigned PrioW   = 16;
  localparam int unsigned MaskW   = 8;
  localparam int unsigned ActW    = 4;
  localparam int unsigned SlotW   = 5;
  localparam int unsigned RegionW = 8;
  localparam int unsigned RegionShift = 24;
  localparam int unsigned EnableBit   = 8;

  localparam logic [PrioW-1:0]   PrioEmpty   = 16'hffff;
  localparam logic [PrioW-1:0]   PrioRemoved = 16'h7fff;
  localparam logic [RegionW-1:0] RegionReset = 8'd2;

  localparam logic [ActW-1:0] ActClear      = 4'd0;
  localparam logic [ActW-1:0] ActFind       = 4'd1;
  localparam logic [ActW-1:0] ActAdd        = 4'd2;
  localparam logic [ActW-1:0] ActRemove     = 4'd3;
  localparam logic [ActW-1:0] ActEnable     = 4'd4;
  localparam logic [ActW-1:0] ActDisable    = 4'd5;
  localparam logic [ActW-1:0] ActOvlEnable  = 4'd6;
  localparam logic [ActW-1:0] ActOvlDisable = 4'd7;
  localparam logic [ActW-1:0] ActSetMask    = 4'd8;

  typedef struct packed {
    logic [HandleW-1:0] handle;
    logic [PrioW-1:0]   prio;
    logic [MaskW-1:0]   mask;
  } entry_t;

  localparam entry_t EntryReset = '{handle: '0, prio: PrioEmpty, mask: '0};

endpackage

[rtl/pct_table_mem.sv]
// ----------------------------------------------------------------------------
// pct_table_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pct_table_mem #(
  parameter int unsigned DEPTH = 20
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr_i,
  output pct_pkg::entry_t            rd_data_o,
  input  logic                       wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr_i,
  input  pct_pkg::entry_t            wr_data_i
);

  pct_pkg::entry_t mem [DEPTH];
  pct_pkg::entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/priority_callback_table_core.sv]
// ----------------------------------------------------------------------------
// priority_callback_table_core
// Callback table kept in one memory, driven by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; done_o is high for
// one cycle and cannot be held off, and the result on hit_o/slot_o stays until
// a new command is taken. Find, remove, set mask, add and enable/disable walk
// the memory entry by entry (read, then check and write back); find, remove
// and set mask stop at the first match, and clear writes every entry in turn.
// Add/update adds a scan, one read-modify-write if a match or empty entry is
// found, and a bubble sort of up to ENTRIES-1 passes, ending early after a
// pass without a swap; the sort passes run through the single memory. After
// reset a clearing pass over all entries runs with busy high; configuration
// writes are always taken.
module priority_callback_table_core #(
  parameter int unsigned ENTRIES = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  action_i,
  input  logic [31:0] handle_i,
  input  logic signed [15:0] priority_req_i,
  input  logic [7:0]  mask_value_i,
  output logic        done_o,
  output logic        hit_o,
  output logic [4:0]  slot_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_SCAN_RD, ST_SCAN_CK, ST_ADD_RD, ST_ADD_WR,
    ST_SRT_RD0, ST_SRT_LD0, ST_SRT_RD, ST_SRT_CK, ST_SRT_END
  } state_e;

  state_e state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d, last_q, last_d;
  logic [IdxW-1:0] match_q, match_d, empty_q, empty_d;
  logic            match_ok_q, match_ok_d, empty_ok_q, empty_ok_d;
  logic            swapped_q, swapped_d, clr_rep_q, clr_rep_d;
  logic            done_q, done_d, hit_q, hit_d;
  logic [IdxW-1:0] res_q, res_d;
  logic [7:0]      region_q, region_d;
  logic [3:0]      act_q, act_d;
  logic [31:0]     h_q, h_d;
  logic [15:0]     prio_q, prio_d;
  logic [7:0]      mval_q, mval_d;
  pct_pkg::entry_t carry_q, carry_d;

  logic            rd_en, wr_en;
  logic [IdxW-1:0] rd_addr, wr_addr;
  pct_pkg::entry_t rd_data, wr_data, ent;
  logic            is_match, sel, at_last;
  logic [IdxW-1:0] tgt;

  pct_table_mem #(.DEPTH(ENTRIES)) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  assign ent      = rd_data;
  assign is_match = (ent.handle == h_q);
  assign at_last  = (idx_q == LastIdx);
  assign tgt      = match_ok_q ? match_q : empty_q;

  always_comb begin
    state_d = state_q;  idx_d = idx_q;  last_d = last_q;
    match_d = match_q;  empty_d = empty_q;
    match_ok_d = match_ok_q;  empty_ok_d = empty_ok_q;
    swapped_d = swapped_q;  clr_rep_d = clr_rep_q;
    done_d = 1'b0;  hit_d = hit_q;  res_d = res_q;
    region_d = region_q;
    act_d = act_q;  h_d = h_q;  prio_d = prio_q;  mval_d = mval_q;
    carry_d = carry_q;
    rd_en = 1'b0;  rd_addr = idx_q;
    wr_en = 1'b0;  wr_addr = idx_q;  wr_data = ent;
    sel = 1'b0;

    if (cfg_valid_i) begin
      region_d = cfg_data_i;
    end

    unique case (state_q)
      ST_CLR: begin
        wr_en   = 1'b1;
        wr_data = pct_pkg::EntryReset;
        idx_d   = idx_q + 1'b1;
        if (at_last) begin
          state_d = ST_IDLE;
          if (clr_rep_q) begin
            done_d = 1'b1;  hit_d = 1'b1;  res_d = '0;
          end
        end
      end
      ST_IDLE: begin
        if (start) begin
          act_d = action_i;  h_d = handle_i;
          prio_d = priority_req_i;  mval_d = mask_value_i;
          idx_d = '0;  match_ok_d = 1'b0;  empty_ok_d = 1'b0;
          hit_d = 1'b0;  res_d = '0;
          if (action_i == pct_pkg::ActClear) begin
            clr_rep_d = 1'b1;
            state_d   = ST_CLR;
          end else if (action_i > pct_pkg::ActSetMask) begin
            done_d = 1'b1;
          end else begin
            state_d = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        rd_en   = 1'b1;
        state_d = ST_SCAN_CK;
      end
      ST_SCAN_CK: begin
        state_d = ST_SCAN_RD;
        idx_d   = idx_q + 1'b1;
        case (act_q)
          pct_pkg::ActFind, pct_pkg::ActRemove, pct_pkg::ActSetMask: begin
            if (is_match) begin
              hit_d = 1'b1;  res_d = idx_q;
              if (act_q == pct_pkg::ActRemove) begin
                wr_en = 1'b1;
                wr_data.handle = '0;
                wr_data.prio   = pct_pkg::PrioRemoved;
              end else if (act_q == pct_pkg::ActSetMask) begin
                wr_en = 1'b1;
                wr_data.mask = mval_q;
              end
              done_d = 1'b1;  state_d = ST_IDLE;
            end else if (at_last) begin
              done_d = 1'b1;  state_d = ST_IDLE;
            end
          end
          pct_pkg::ActAdd: begin
            if (is_match && !match_ok_q) begin
              match_ok_d = 1'b1;  match_d = idx_q;
            end
            if (ent.handle == '0 && !empty_ok_q) begin
              empty_ok_d = 1'b1;  empty_d = idx_q;
            end
            if (at_last) begin
              state_d = ST_ADD_RD;
            end
          end
          default: begin
            // enable/disable variants: touch every selected entry
            if (act_q == pct_pkg::ActEnable || act_q == pct_pkg::ActDisable) begin
              sel = (h_q == '0) || is_match;
            end else begin
              sel = (ent.handle[pct_pkg::RegionShift +: 8] == region_q) &&
                    ((act_q == pct_pkg::ActOvlDisable) || !ent.mask[0]);
            end
            if (sel) begin
              wr_en = 1'b1;
              wr_data.prio[pct_pkg::EnableBit] =
                (act_q == pct_pkg::ActEnable) || (act_q == pct_pkg::ActOvlEnable);
              hit_d = 1'b1;  res_d = idx_q;
            end
            if (at_last) begin
              done_d = 1'b1;  state_d = ST_IDLE;
            end
          end
        endcase
      end
      ST_ADD_RD: begin
        if (match_ok_q || empty_ok_q) begin
          rd_en   = 1'b1;  rd_addr = tgt;
          state_d = ST_ADD_WR;
        end else begin
          last_d = LastIdx;  state_d = ST_SRT_RD0;
        end
      end
      ST_ADD_WR: begin
        wr_en   = 1'b1;  wr_addr = tgt;
        wr_data.prio = prio_q;
        if (!match_ok_q) begin
          wr_data.handle = h_q;  wr_data.mask = '0;
        end
        hit_d  = 1'b1;  res_d = tgt;
        last_d = LastIdx;  state_d = ST_SRT_RD0;
      end
      ST_SRT_RD0: begin
        rd_en = 1'b1;  rd_addr = '0;
        swapped_d = 1'b0;
        state_d = ST_SRT_LD0;
      end
      ST_SRT_LD0: begin
        carry_d = ent;  idx_d = IdxW'(1);
        state_d = ST_SRT_RD;
      end
      ST_SRT_RD: begin
        rd_en   = 1'b1;
        state_d = ST_SRT_CK;
      end
      ST_SRT_CK: begin
        // carry holds the entry sinking toward the end of this pass
        wr_en   = 1'b1;  wr_addr = idx_q - 1'b1;
        if ($signed(ent.prio) > $signed(carry_q.prio)) begin
          wr_data = ent;  swapped_d = 1'b1;
        end else begin
          wr_data = carry_q;  carry_d = ent;
        end
        if (idx_q == last_q) begin
          state_d = ST_SRT_END;
        end else begin
          idx_d = idx_q + 1'b1;  state_d = ST_SRT_RD;
        end
      end
      ST_SRT_END: begin
        wr_en = 1'b1;  wr_addr = last_q;  wr_data = carry_q;
        if (swapped_q && last_q > IdxW'(1)) begin
          last_d = last_q - 1'b1;  state_d = ST_SRT_RD0;
        end else begin
          done_d = 1'b1;  state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;  idx_q <= '0;  last_q <= '0;
      match_q <= '0;  empty_q <= '0;  match_ok_q <= 1'b0;  empty_ok_q <= 1'b0;
      swapped_q <= 1'b0;  clr_rep_q <= 1'b0;
      done_q <= 1'b0;  hit_q <= 1'b0;  res_q <= '0;
      region_q <= pct_pkg::RegionReset;  act_q <= '0;
    end else begin
      state_q <= state_d;  idx_q <= idx_d;  last_q <= last_d;
      match_q <= match_d;  empty_q <= empty_d;
      match_ok_q <= match_ok_d;  empty_ok_q <= empty_ok_d;
      swapped_q <= swapped_d;  clr_rep_q <= clr_rep_d;
      done_q <= done_d;  hit_q <= hit_d;  res_q <= res_d;
      region_q <= region_d;  act_q <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d;  prio_q <= prio_d;  mval_q <= mval_d;  carry_q <= carry_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign hit_o       = hit_q;
  assign slot_o      = hit_q ? pct_pkg::SlotW'(res_q) : '0;

endmodule
